// ===== sv/ptd_pkg.sv =====
package ptd_pkg;

  localparam int TASK_SLOTS_DEF = 8;
  localparam int TASK_SLOTS_MAX = 64;

  localparam int DELAY_W  = 15;
  localparam int PERIOD_W = 15;
  localparam int TIME_W   = 32;
  localparam int SLOT_W   = 3;

  localparam logic [TIME_W-1:0] IDLE_NONE = 32'hFFFF_FFFF;

  localparam logic OP_START    = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic                op;
    logic [DELAY_W-1:0]  start_delay;
    logic [PERIOD_W-1:0] task_period;
    logic [TIME_W-1:0]   elapsed_ms;
  } ptd_in_t;

  typedef struct packed {
    logic [SLOT_W-1:0] assigned_slot;
    logic              table_full;
    logic              run_valid;
    logic [SLOT_W-1:0] run_slot;
    logic [TIME_W-1:0] idle_ms;
  } ptd_out_t;

  typedef enum logic {
    CMD_START,
    CMD_DISPATCH
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [DELAY_W-1:0]  start_delay;
    logic [PERIOD_W-1:0] task_period;
    logic [TIME_W-1:0]   elapsed_ms;
  } ptd_cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_WALK
  } back_state_t;

endpackage

// ===== sv/ptd_ram.sv =====
module ptd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/ptd_front.sv =====
module ptd_front
  import ptd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  ptd_in_t  in_item,
  input  logic     q_ready,
  output logic     q_push,
  output ptd_cmd_t q_item
);

  logic     cmd_vld_r, cmd_vld_nxt;
  ptd_cmd_t cmd_r, cmd_nxt;
  logic     accept;

  // holding stage frees up whenever the queue takes the item
  assign busy   = cmd_vld_r && !q_ready;
  assign accept = start && !busy;
  assign q_push = cmd_vld_r && q_ready;
  assign q_item = cmd_r;

  always_comb begin
    cmd_vld_nxt = q_push ? 1'b0 : cmd_vld_r;
    cmd_nxt     = cmd_r;
    if (accept) begin
      cmd_vld_nxt         = 1'b1;
      cmd_nxt.kind        = (in_item.op == OP_DISPATCH) ? CMD_DISPATCH : CMD_START;
      cmd_nxt.start_delay = in_item.start_delay;
      cmd_nxt.task_period = in_item.task_period;
      cmd_nxt.elapsed_ms  = in_item.elapsed_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_vld_r <= 1'b0;
    end else begin
      cmd_vld_r <= cmd_vld_nxt;
    end
    cmd_r <= cmd_nxt;
  end

endmodule

// ===== sv/ptd_queue.sv =====
module ptd_queue
  import ptd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  ptd_cmd_t push_item,
  output logic     pop_valid,
  input  logic     pop_ready,
  output ptd_cmd_t pop_item
);

  ptd_cmd_t            entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign push_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== sv/ptd_back.sv =====
module ptd_back
  import ptd_pkg::*;
#(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_valid,
  output logic     q_pop,
  input  ptd_cmd_t q_item,
  output logic     out_valid,
  output ptd_out_t out_item
);

  localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CW = $clog2(TASK_SLOTS + 1);

  back_state_t           state_r, state_nxt;
  logic [CW-1:0]         rd_cnt_r, rd_cnt_nxt;
  logic                  ev_vld_r, ev_vld_nxt;
  logic [IW-1:0]         ev_idx_r, ev_idx_nxt;
  logic [TIME_W-1:0]     elapsed_r, elapsed_nxt;
  logic                  found_r, found_nxt;
  logic [IW-1:0]         slot_r, slot_nxt;
  logic [TIME_W-1:0]     idle_r, idle_nxt;
  logic [CW-1:0]         next_slot_r, next_slot_nxt;
  logic [TASK_SLOTS-1:0] running_r, running_nxt;
  logic                  out_valid_r, out_valid_nxt;
  ptd_out_t              out_item_r, out_item_nxt;

  logic                  rem_we, per_we;
  logic [IW-1:0]         rem_waddr, raddr;
  logic [TIME_W-1:0]     rem_wdata, rem_rdata;
  logic [PERIOD_W-1:0]   per_rdata;

  logic [TIME_W-1:0]     rem_sub;
  logic                  slot_run, slot_due, last_slot, table_full;

  assign raddr     = rd_cnt_r[IW-1:0];
  assign rem_sub   = rem_rdata - elapsed_r;
  assign slot_due  = (rem_sub == '0) || rem_sub[TIME_W-1];
  assign slot_run  = running_r[ev_idx_r];
  assign last_slot = (ev_idx_r == IW'(TASK_SLOTS - 1));
  assign table_full = (next_slot_r >= CW'(TASK_SLOTS));
  assign q_pop     = (state_r == BK_IDLE) && q_valid;

  ptd_ram #(.WIDTH(TIME_W), .DEPTH(TASK_SLOTS)) u_rem_ram (
    .clk   (clk),
    .we    (rem_we),
    .waddr (rem_waddr),
    .wdata (rem_wdata),
    .raddr (raddr),
    .rdata (rem_rdata)
  );

  ptd_ram #(.WIDTH(PERIOD_W), .DEPTH(TASK_SLOTS)) u_per_ram (
    .clk   (clk),
    .we    (per_we),
    .waddr (next_slot_r[IW-1:0]),
    .wdata (q_item.task_period),
    .raddr (raddr),
    .rdata (per_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid && q_item.kind == CMD_DISPATCH) begin
          state_nxt = BK_WALK;
        end
      end
      BK_WALK: begin
        if (ev_vld_r && last_slot) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    rd_cnt_nxt    = rd_cnt_r;
    ev_vld_nxt    = 1'b0;
    ev_idx_nxt    = ev_idx_r;
    elapsed_nxt   = elapsed_r;
    found_nxt     = found_r;
    slot_nxt      = slot_r;
    idle_nxt      = idle_r;
    next_slot_nxt = next_slot_r;
    running_nxt   = running_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    rem_we        = 1'b0;
    rem_waddr     = ev_idx_r;
    rem_wdata     = rem_sub;
    per_we        = 1'b0;

    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          if (q_item.kind == CMD_START) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '0;
            if (table_full) begin
              out_item_nxt.table_full = 1'b1;
            end else begin
              rem_we    = 1'b1;
              rem_waddr = next_slot_r[IW-1:0];
              rem_wdata = TIME_W'(q_item.start_delay);
              per_we    = 1'b1;
              running_nxt[next_slot_r[IW-1:0]] = 1'b1;
              next_slot_nxt = next_slot_r + 1'b1;
              out_item_nxt.assigned_slot = SLOT_W'(next_slot_r);
            end
          end else begin
            rd_cnt_nxt  = '0;
            elapsed_nxt = q_item.elapsed_ms;
            found_nxt   = 1'b0;
            slot_nxt    = '0;
            idle_nxt    = IDLE_NONE;
          end
        end
      end
      BK_WALK: begin
        // read of slot k overlaps the update of slot k-1
        if (rd_cnt_r < CW'(TASK_SLOTS)) begin
          ev_vld_nxt = 1'b1;
          ev_idx_nxt = rd_cnt_r[IW-1:0];
          rd_cnt_nxt = rd_cnt_r + 1'b1;
        end
        if (ev_vld_r && slot_run) begin
          rem_we = 1'b1;
          if (slot_due) begin
            idle_nxt = '0;
            if (!found_r) begin
              found_nxt = 1'b1;
              slot_nxt  = ev_idx_r;
              rem_wdata = rem_sub + TIME_W'(per_rdata);
            end
          end else if (rem_sub < idle_r) begin
            idle_nxt = rem_sub;
          end
        end
        if (ev_vld_r && last_slot) begin
          out_valid_nxt          = 1'b1;
          out_item_nxt           = '0;
          out_item_nxt.run_valid = found_nxt;
          out_item_nxt.run_slot  = SLOT_W'(slot_nxt);
          out_item_nxt.idle_ms   = idle_nxt;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      ev_vld_r    <= 1'b0;
      next_slot_r <= '0;
      running_r   <= '0;
      out_valid_r <= 1'b0;
      rd_cnt_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      ev_vld_r    <= ev_vld_nxt;
      next_slot_r <= next_slot_nxt;
      running_r   <= running_nxt;
      out_valid_r <= out_valid_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
    end
    ev_idx_r   <= ev_idx_nxt;
    elapsed_r  <= elapsed_nxt;
    found_r    <= found_nxt;
    slot_r     <= slot_nxt;
    idle_r     <= idle_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== sv/periodic_task_dispatcher_top.sv =====
// periodic task dispatcher: table of TASK_SLOTS periodic tasks
// input: raise start with in_item while busy is low; the item is taken at that edge.
//   op start fills the next free slot with start_delay and task_period or,
//   if none is left, flags table_full; op dispatch subtracts elapsed_ms from
//   every running task and picks the lowest-index due task, adding its period back.
// output: one item per input, shown for one cycle with out_valid high;
//   the receiver must take it then, there is no backpressure.
// path: with the slot walk idle a start item passes the input holding register
//   and the queue entry before the output register; a dispatch result waits for
//   the slot walk that reads the remaining-time ram one slot per cycle.
// throughput: one start per cycle outside a walk; a walk takes no new item
//   until it has covered all slots. a two-item queue after the input stage
//   keeps taking items during a walk; busy rises when it and that stage fill.
// reset: synchronous, active low; clears all running flags, the slot count and
//   control state; the rams are not cleared, a slot's times count only once started.
module periodic_task_dispatcher_top
  import ptd_pkg::*;
#(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  ptd_in_t  in_item,
  output logic     out_valid,
  output ptd_out_t out_item
);

  logic     f_push, f_ready;
  ptd_cmd_t f_item;
  logic     b_valid, b_pop;
  ptd_cmd_t b_item;

  ptd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .q_ready (f_ready),
    .q_push  (f_push),
    .q_item  (f_item)
  );

  ptd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_push),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (b_valid),
    .pop_ready  (b_pop),
    .pop_item   (b_item)
  );

  ptd_back #(.TASK_SLOTS(TASK_SLOTS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (b_valid),
    .q_pop     (b_pop),
    .q_item    (b_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ===== dv/tb_periodic_task_dispatcher_top.sv =====
module tb_periodic_task_dispatcher_top;
  import ptd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS       = TASK_SLOTS_DEF;
  localparam int N_RANDOM    = 780;
  localparam int QUIET_TAIL  = 100;
  localparam int CYCLE_LIMIT = 200000;

  logic     clk;
  logic     rst_n   = 1'b0;
  logic     start   = 1'b0;
  ptd_in_t  in_item = '0;
  logic     busy;
  logic     out_valid;
  ptd_out_t out_item;

  periodic_task_dispatcher_top #(
    .TASK_SLOTS(SLOTS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // task table as the scheduler should hold it
  logic [TIME_W-1:0]   task_remaining [SLOTS];
  logic [PERIOD_W-1:0] task_period_of [SLOTS];
  logic                task_running   [SLOTS];
  int                  slots_used = 0;

  ptd_in_t  pending_cmds[$];
  ptd_out_t expected_results[$];

  int   cmds_taken    = 0;
  int   results_seen  = 0;
  int   runs_seen     = 0;
  int   full_seen     = 0;
  int   mismatches    = 0;
  int   cycle_count   = 0;
  int   gap_left      = 0;
  int   n_directed    = 0;
  bit   gaps_on       = 1'b1;
  bit   drain_hold    = 1'b0;

  initial begin
    for (int i = 0; i < SLOTS; i++) task_running[i] = 1'b0;
  end

  function automatic ptd_out_t schedule_step(ptd_in_t cmd);
    ptd_out_t          res;
    logic [TIME_W-1:0] least;
    res = '0;
    if (cmd.op == OP_START) begin
      if (slots_used < SLOTS) begin
        task_remaining[slots_used] = TIME_W'(cmd.start_delay);
        task_period_of[slots_used] = cmd.task_period;
        task_running[slots_used]   = 1'b1;
        res.assigned_slot          = SLOT_W'(slots_used);
        slots_used++;
      end else begin
        res.table_full = 1'b1;
      end
    end else begin
      least = IDLE_NONE;
      for (int i = 0; i < SLOTS; i++) begin
        if (task_running[i]) begin
          task_remaining[i] = task_remaining[i] - cmd.elapsed_ms;
          // due when signed remaining time is zero or negative
          if (task_remaining[i] == '0 || task_remaining[i][TIME_W-1]) begin
            if (!res.run_valid) begin
              res.run_valid     = 1'b1;
              res.run_slot      = SLOT_W'(i);
              task_remaining[i] = task_remaining[i] + TIME_W'(task_period_of[i]);
            end
            least = '0;
          end else if (task_remaining[i] < least) begin
            least = task_remaining[i];
          end
        end
      end
      res.idle_ms = least;
    end
    return res;
  endfunction

  function automatic ptd_in_t start_cmd(int unsigned delay, int unsigned period);
    ptd_in_t cmd;
    cmd             = '0;
    cmd.op          = OP_START;
    cmd.start_delay = DELAY_W'(delay);
    cmd.task_period = PERIOD_W'(period);
    return cmd;
  endfunction

  function automatic ptd_in_t dispatch_cmd(logic [TIME_W-1:0] elapsed);
    ptd_in_t cmd;
    cmd            = '0;
    cmd.op         = OP_DISPATCH;
    cmd.elapsed_ms = elapsed;
    return cmd;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch on result %0d: %s", $realtime, results_seen, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [TIME_W-1:0] got, logic [TIME_W-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_results.push_back(schedule_step(in_item));
        cmds_taken++;
        if (cmds_taken % 50 == 0) gaps_on = bit'($urandom_range(0, 1));
        if (gaps_on && pending_cmds.size() > QUIET_TAIL && $urandom_range(0, 3) == 0)
          gap_left = $urandom_range(1, 5);
        // let the block drain completely at two points
        if (cmds_taken == n_directed || cmds_taken == n_directed + N_RANDOM / 2)
          drain_hold = 1'b1;
      end
      if (drain_hold && expected_results.size() == 0) drain_hold = 1'b0;

      if (start && busy) begin
        // item still waiting, keep it up
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (drain_hold) begin
        start <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        in_item <= pending_cmds.pop_front();
        start   <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    ptd_out_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = expected_results.pop_front();
        check_field("assigned_slot", TIME_W'(out_item.assigned_slot),
                    TIME_W'(want.assigned_slot));
        check_field("table_full", TIME_W'(out_item.table_full), TIME_W'(want.table_full));
        check_field("run_valid", TIME_W'(out_item.run_valid), TIME_W'(want.run_valid));
        check_field("run_slot", TIME_W'(out_item.run_slot), TIME_W'(want.run_slot));
        check_field("idle_ms", out_item.idle_ms, want.idle_ms);
        if (want.run_valid) runs_seen++;
        if (want.table_full) full_seen++;
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items still expected", cycle_count,
               expected_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    ptd_in_t     cmd;
    int unsigned sel;

    // empty table, then filling it with dispatches in between
    pending_cmds.push_back(dispatch_cmd(32'h0));
    pending_cmds.push_back(dispatch_cmd(32'hFFFF_FFFF));
    pending_cmds.push_back(start_cmd(0, 32767));
    pending_cmds.push_back(dispatch_cmd(32'h0));
    pending_cmds.push_back(dispatch_cmd(32'h0));
    pending_cmds.push_back(start_cmd(32767, 5000));
    pending_cmds.push_back(start_cmd(5, 3000));
    pending_cmds.push_back(dispatch_cmd(32'd5));
    pending_cmds.push_back(start_cmd(1, 7000));
    pending_cmds.push_back(start_cmd(200, 12000));
    pending_cmds.push_back(start_cmd(15'h2AAA, 15'h5555));
    pending_cmds.push_back(start_cmd(15'h5555, 15'h2AAA));
    pending_cmds.push_back(dispatch_cmd(32'd100));
    // zero period: once due it stays due
    pending_cmds.push_back(start_cmd(32767, 0));
    // table is full from here on
    pending_cmds.push_back(start_cmd(10, 10));
    pending_cmds.push_back(dispatch_cmd(32'h7FFF_FFFF));
    pending_cmds.push_back(dispatch_cmd(32'h8000_0000));
    pending_cmds.push_back(dispatch_cmd(32'hFFFF_FFFF));
    pending_cmds.push_back(dispatch_cmd(32'd1));
    pending_cmds.push_back(dispatch_cmd(32'h0));
    n_directed = pending_cmds.size();

    for (int n = 0; n < N_RANDOM; n++) begin
      sel             = $urandom_range(0, 99);
      cmd.start_delay = DELAY_W'($urandom);
      cmd.task_period = PERIOD_W'($urandom);
      cmd.elapsed_ms  = $urandom;
      if (sel < 5) begin
        cmd.op = OP_START;
      end else begin
        cmd.op = OP_DISPATCH;
        if (sel < 70) begin
          cmd.elapsed_ms = $urandom_range(0, 300);
        end else if (sel < 82) begin
          // wraps to a small step back in time
          cmd.elapsed_ms = 32'h0 - $urandom_range(1, 4000);
        end else if (sel >= 92) begin
          case ($urandom_range(0, 3))
            0: cmd.elapsed_ms = 32'h0;
            1: cmd.elapsed_ms = 32'hFFFF_FFFF;
            2: cmd.elapsed_ms = 32'h7FFF_FFFF;
            default: cmd.elapsed_ms = 32'h8000_0000;
          endcase
        end
      end
      pending_cmds.push_back(cmd);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || start) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SLOTS + 20) @(posedge clk);

    $display("%0d items checked against the task table model over %0d cycles",
             results_seen, cycle_count);
    $display("%0d dispatches ran a due task, %0d starts hit a full table",
             runs_seen, full_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
